// ----- rtl/mi3_pkg.sv -----
// Shared constants and width helpers for the 3x3 matrix inverse block.
// No dependencies; used by mi3_front, mi3_lane and matrix_inverse_3x3.
`timescale 1ns / 1ps

package mi3_pkg;

    // Default element format: signed Q16.16.
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Register stages from the input ports to the registered determinant.
    localparam int FRONT_LAT = 5;

    // An adjugate entry is a difference of two full products.
    function automatic int adj_w(input int w);
        return 2 * w + 1;
    endfunction

    // The determinant is a sum of three element-by-adjugate products.
    function automatic int det_w(input int w);
        return 3 * w + 3;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/matrix_inverse_3x3.sv -----
// Top level of the 3x3 signed fixed-point matrix inverse.
// Depends on mi3_pkg, mi3_front and mi3_lane.
`timescale 1ns / 1ps

// Usage
// The input channel carries one 3x3 matrix per item (in_r0c0 .. in_r2c2,
// signed Q format) and is accepted when in_valid is high and in_stall low.
// The output channel returns the inverse (inv_r0c0 .. inv_r2c2) and the
// singular flag; the receiver takes an item when out_valid is high and
// out_stall low. A singular matrix gives all-zero elements with singular set.
// Every element is the exact quotient of its adjugate entry by the
// determinant, rounded to nearest with ties away from zero and saturated.
// From the accepting edge to out_valid an item passes five front stages for
// the cofactors and determinant, ELEM_WIDTH + 3 stages in the nine divider
// lanes, whose step stages each resolve one quotient bit, then the output
// register. The first front stage loads at the accepting edge. One item is
// accepted every cycle while in_stall is low. When the receiver stalls, a
// one-entry skid register catches the item that leaves the pipeline; in_stall
// rises only while that register is full, and the whole pipeline then holds.
// Reset clears all valid bits; no payload is cleared and no clearing pass is
// needed.
module matrix_inverse_3x3 #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c2,
    output logic                         singular
);

    localparam int AW       = mi3_pkg::adj_w(ELEM_WIDTH);
    localparam int DW       = mi3_pkg::det_w(ELEM_WIDTH);
    localparam int LANE_LAT = ELEM_WIDTH + 3;
    localparam int PIPE_LAT = mi3_pkg::FRONT_LAT + LANE_LAT;

    logic                         en;
    logic signed [ELEM_WIDTH-1:0] a [9];
    logic signed [AW-1:0]         adj [9];
    logic signed [DW-1:0]         det;
    logic        [DW-1:0]         dabs;
    logic                         det_neg;
    logic                         det_zero;
    logic signed [ELEM_WIDTH-1:0] lane_res [9];
    logic signed [ELEM_WIDTH-1:0] merged [9];

    logic [PIPE_LAT-1:0]          vld_reg;
    logic [LANE_LAT-1:0]          sing_reg;
    logic                         vld_last;
    logic                         sing_last;

    logic                         out_valid_reg;
    logic                         skid_full_reg;
    logic signed [ELEM_WIDTH-1:0] out_reg  [9];
    logic                         out_sing_reg;
    logic signed [ELEM_WIDTH-1:0] skid_reg [9];
    logic                         skid_sing_reg;

    // The pipeline moves whenever the skid register has room.
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    assign a[0] = in_r0c0;
    assign a[1] = in_r0c1;
    assign a[2] = in_r0c2;
    assign a[3] = in_r1c0;
    assign a[4] = in_r1c1;
    assign a[5] = in_r1c2;
    assign a[6] = in_r2c0;
    assign a[7] = in_r2c1;
    assign a[8] = in_r2c2;

    mi3_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk (clk),
        .en  (en),
        .a   (a),
        .adj (adj),
        .det (det)
    );

    // Determinant sign and magnitude are shared by all nine lanes.
    assign det_neg  = det[DW-1];
    assign det_zero = (det == '0);
    assign dabs     = det_neg ? DW'(-det) : DW'(det);

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_lane #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .adj     (adj[k]),
            .dabs    (dabs),
            .det_neg (det_neg),
            .res     (lane_res[k])
        );

        // Merge: a singular matrix overrides whatever its lane produced.
        assign merged[k] = sing_last ? '0 : lane_res[k];
    end

    assign vld_last  = vld_reg[PIPE_LAT-1];
    assign sing_last = sing_reg[LANE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= {sing_reg[LANE_LAT-2:0], det_zero};
        end
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_full_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= vld_last;
            end
        end
        else if (en && vld_last)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_full_reg)
            begin
                out_reg      <= skid_reg;
                out_sing_reg <= skid_sing_reg;
            end
            else
            begin
                out_reg      <= merged;
                out_sing_reg <= sing_last;
            end
        end
        else if (en)
        begin
            skid_reg      <= merged;
            skid_sing_reg <= sing_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign singular  = out_sing_reg;
    assign inv_r0c0  = out_reg[0];
    assign inv_r0c1  = out_reg[1];
    assign inv_r0c2  = out_reg[2];
    assign inv_r1c0  = out_reg[3];
    assign inv_r1c1  = out_reg[4];
    assign inv_r1c2  = out_reg[5];
    assign inv_r2c0  = out_reg[6];
    assign inv_r2c1  = out_reg[7];
    assign inv_r2c2  = out_reg[8];

`ifndef SYNTHESIS
    // The skid register only fills behind a result that is being held.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid register full without a valid output");

    // A full skid register drains as soon as the receiver takes the output.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && !out_stall) |=> !skid_full_reg)
        else $error("skid register did not drain");

    // A singular result carries all-zero elements; the diagonal and r0c2 are checked.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sing_reg) |->
            (inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0 && inv_r0c2 == '0))
        else $error("singular result with nonzero elements");
`endif

endmodule

// ----- rtl/mi3_front.sv -----
// Front end of the 3x3 inverse: cofactor products, adjugate and determinant.
// Depends on mi3_pkg for width helpers.
`timescale 1ns / 1ps

module mi3_front #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic signed [ELEM_WIDTH-1:0]                    a   [9],
    output logic signed [mi3_pkg::adj_w(ELEM_WIDTH)-1:0]    adj [9],
    output logic signed [mi3_pkg::det_w(ELEM_WIDTH)-1:0]    det
);

    localparam int W  = ELEM_WIDTH;
    localparam int AW = mi3_pkg::adj_w(ELEM_WIDTH);
    localparam int DW = mi3_pkg::det_w(ELEM_WIDTH);
    localparam int PW = 3 * ELEM_WIDTH + 2;

    logic signed [2*W-1:0] p1_reg [9];
    logic signed [2*W-1:0] p2_reg [9];
    logic signed [AW-1:0]  adj2_reg [9];
    logic signed [AW-1:0]  adj3_reg [9];
    logic signed [AW-1:0]  adj4_reg [9];
    logic signed [AW-1:0]  adj5_reg [9];
    logic signed [W-1:0]   a01_reg [3];
    logic signed [W-1:0]   a02_reg [3];
    logic signed [2*W:0]   pplo_reg [3];
    logic signed [2*W:0]   pphi_reg [3];
    logic signed [PW-1:0]  pr_reg [3];
    logic signed [DW-1:0]  det_reg;

    // Each adjugate entry is the transposed cofactor, built from two products.
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int K  = i * 3 + j;
            localparam int IA = ((j + 1) % 3) * 3 + (i + 1) % 3;
            localparam int IB = ((j + 2) % 3) * 3 + (i + 2) % 3;
            localparam int IC = ((j + 1) % 3) * 3 + (i + 2) % 3;
            localparam int ID = ((j + 2) % 3) * 3 + (i + 1) % 3;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p1_reg[K]   <= a[IA] * a[IB];
                    p2_reg[K]   <= a[IC] * a[ID];
                    adj2_reg[K] <= AW'(p1_reg[K]) - AW'(p2_reg[K]);
                    adj3_reg[K] <= adj2_reg[K];
                    adj4_reg[K] <= adj3_reg[K];
                    adj5_reg[K] <= adj4_reg[K];
                end
            end
        end
    end

    // Determinant along row 0; each wide product is split in two halves.
    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a01_reg[j]  <= a[j];
                a02_reg[j]  <= a01_reg[j];
                pplo_reg[j] <= a02_reg[j] * $signed({1'b0, adj2_reg[j*3][W-1:0]});
                pphi_reg[j] <= a02_reg[j] * $signed(adj2_reg[j*3][AW-1:W]);
                pr_reg[j]   <= (PW'(pphi_reg[j]) <<< W) + PW'(pplo_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= DW'(pr_reg[0]) + DW'(pr_reg[1]) + DW'(pr_reg[2]);
        end
    end

    assign adj = adj5_reg;
    assign det = det_reg;

endmodule

// ----- rtl/mi3_lane.sv -----
// One division lane: rounded, saturated quotient adj * 2^(2F) / det.
// Depends on mi3_pkg for width helpers; one quotient bit per step stage.
`timescale 1ns / 1ps

module mi3_lane #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic signed [mi3_pkg::adj_w(ELEM_WIDTH)-1:0]    adj,
    input  logic        [mi3_pkg::det_w(ELEM_WIDTH)-1:0]    dabs,
    input  logic                                            det_neg,
    output logic signed [ELEM_WIDTH-1:0]                    res
);

    localparam int W  = ELEM_WIDTH;
    localparam int AW = mi3_pkg::adj_w(ELEM_WIDTH);
    localparam int DW = mi3_pkg::det_w(ELEM_WIDTH);
    localparam int NW = mi3_pkg::max_int(AW + 2 * FRAC_BITS + 1, DW) + 1;
    localparam int RW = DW + 1;
    localparam int XW = mi3_pkg::max_int(NW - W, RW);

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    logic [AW-1:0] mag;
    logic [NW-1:0] num_next;
    logic [NW-1:0] num_reg;
    logic [RW-1:0] d0_reg;
    logic          neg0_reg;
    logic [XW-1:0] hi_x;
    logic [XW-1:0] d_x;

    logic [RW-1:0] rem_reg [W+1];
    logic [W-1:0]  low_reg [W+1];
    logic [W-1:0]  q_reg   [W+1];
    logic [RW-1:0] d_reg   [W+1];
    logic          neg_reg [W+1];
    logic          ovf_reg [W+1];

    logic [W-1:0]  q;
    logic [W-1:0]  res_next;
    logic [W-1:0]  res_reg;

    // Rounding: floor((|adj| * 2^(2F+1) + |det|) / (2 |det|)).
    assign mag      = adj[AW-1] ? AW'(-adj) : AW'(adj);
    assign num_next = (NW'(mag) << (2 * FRAC_BITS + 1)) + NW'(dabs);

    assign hi_x = XW'(num_reg[NW-1:W]);
    assign d_x  = XW'(d0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= num_next;
            d0_reg     <= {dabs, 1'b0};
            neg0_reg   <= adj[AW-1] ^ det_neg;
            // The quotient exceeds W bits exactly when the top part reaches the divisor.
            ovf_reg[0] <= hi_x >= d_x;
            rem_reg[0] <= RW'(num_reg[NW-1:W]);
            low_reg[0] <= num_reg[W-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= d0_reg;
            neg_reg[0] <= neg0_reg;
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_step
        logic [RW:0] part;
        logic [RW:0] diff;
        logic        ge;
        logic [RW-1:0] rem_next;

        assign part     = {rem_reg[s], low_reg[s][W-1]};
        assign ge       = part >= {1'b0, d_reg[s]};
        assign diff     = part - {1'b0, d_reg[s]};
        assign rem_next = ge ? diff[RW-1:0] : part[RW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                low_reg[s+1] <= {low_reg[s][W-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][W-2:0], ge};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign q = q_reg[W];

    always_comb
    begin
        if (ovf_reg[W])
        begin
            res_next = neg_reg[W] ? NEG_MIN : POS_MAX;
        end
        else if (!neg_reg[W] && q[W-1])
        begin
            res_next = POS_MAX;
        end
        else if (neg_reg[W] && (q > NEG_MIN))
        begin
            res_next = NEG_MIN;
        end
        else
        begin
            res_next = neg_reg[W] ? (~q + 1'b1) : q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = $signed(res_reg);

endmodule

// ----- tb/matrix_inverse_3x3_test.sv -----
// Self-checking testbench for the 3x3 signed fixed-point matrix inverse.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL; needs no other files.
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;

    localparam int W      = mi3_pkg::ELEM_WIDTH_DEF;
    localparam int FB     = mi3_pkg::FRAC_BITS_DEF;
    // Exact arithmetic width: the scaled adjugate needs about 2*W + 2*FB + 2 bits.
    localparam int WIDE   = 4 * W;
    localparam int LAT    = W + 9;
    localparam logic signed [W-1:0] ONE  = 1 <<< FB;
    localparam logic signed [W-1:0] EMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] EMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct {
        logic signed [W-1:0] e[9];
    } matrix_t;

    typedef struct {
        logic signed [W-1:0] e[9];
        logic                singular;
    } inverse_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    logic signed [W-1:0] in_e[9];
    logic signed [W-1:0] inv_e[9];
    logic singular;

    // Expected inverses, oldest first, in the order the matrices were accepted.
    inverse_t pending_inverses[$];
    int error_count = 0;
    // Chance in a hundred that the sender idles or the receiver stalls a cycle.
    int idle_pct  = 0;
    int stall_pct = 0;

    matrix_inverse_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_r0c0   (in_e[0]),
        .in_r0c1   (in_e[1]),
        .in_r0c2   (in_e[2]),
        .in_r1c0   (in_e[3]),
        .in_r1c1   (in_e[4]),
        .in_r1c2   (in_e[5]),
        .in_r2c0   (in_e[6]),
        .in_r2c1   (in_e[7]),
        .in_r2c2   (in_e[8]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .inv_r0c0  (inv_e[0]),
        .inv_r0c1  (inv_e[1]),
        .inv_r0c2  (inv_e[2]),
        .inv_r1c0  (inv_e[3]),
        .inv_r1c1  (inv_e[4]),
        .inv_r1c2  (inv_e[5]),
        .inv_r2c0  (inv_e[6]),
        .inv_r2c1  (inv_e[7]),
        .inv_r2c2  (inv_e[8]),
        .singular  (singular)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Exact inverse: each element is adj/det, rounded half away from zero by
    // computing (2*|adj|*2^(2*FB) + |det|) / (2*|det|), then clamped to the range.
    function automatic inverse_t compute_inverse(input matrix_t m);
        inverse_t res;
        logic signed [WIDE-1:0] a[9];
        logic signed [WIDE-1:0] adj[9];
        logic signed [WIDE-1:0] det;
        logic [WIDE-1:0] det_mag;
        logic [WIDE-1:0] num;
        logic [WIDE-1:0] quot;
        logic [WIDE-1:0] limit;
        logic negative;
        int i;
        int j;
        for (i = 0; i < 9; i++)
        begin
            a[i] = m.e[i];
        end
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                adj[i*3+j] = a[((j+1)%3)*3 + (i+1)%3] * a[((j+2)%3)*3 + (i+2)%3]
                           - a[((j+1)%3)*3 + (i+2)%3] * a[((j+2)%3)*3 + (i+1)%3];
            end
        end
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        res.singular = (det == 0);
        det_mag = (det < 0) ? -det : det;
        for (i = 0; i < 9; i++)
        begin
            if (res.singular)
            begin
                res.e[i] = '0;
            end
            else
            begin
                negative = (adj[i] < 0) != (det < 0);
                num = (adj[i] < 0) ? -adj[i] : adj[i];
                quot = ((num << (2 * FB + 1)) + det_mag) / (det_mag << 1);
                if (quot == 0)
                begin
                    negative = 1'b0;
                end
                limit = negative ? (WIDE'(1) << (W - 1)) : ((WIDE'(1) << (W - 1)) - 1);
                if (quot > limit)
                begin
                    quot = limit;
                end
                res.e[i] = negative ? W'(-quot) : W'(quot);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [W-1:0] got,
                                   input logic signed [W-1:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Drives one matrix and returns once it has been accepted. Inputs move at
    // the falling edge; acceptance is judged at the rising edge.
    task automatic send_matrix(input matrix_t m);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            in_e[i] <= m.e[i];
        end
        forever
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                break;
            end
        end
        pending_inverses.push_back(compute_inverse(m));
    endtask

    // Lowers valid after the last item of a burst.
    task automatic go_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_inverses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic matrix_t diag_matrix(input logic signed [W-1:0] d0,
                                            input logic signed [W-1:0] d1,
                                            input logic signed [W-1:0] d2);
        matrix_t m;
        foreach (m.e[i])
        begin
            m.e[i] = '0;
        end
        m.e[0] = d0;
        m.e[4] = d1;
        m.e[8] = d2;
        return m;
    endfunction

    // Random matrix of one of several shapes: small well-conditioned values, raw
    // full-range bits, singular matrices, zero pivots and scaled permutations.
    function automatic matrix_t random_matrix();
        matrix_t m;
        int shape;
        int p;
        shape = $urandom_range(9);
        foreach (m.e[i])
        begin
            if (shape <= 3)
            begin
                m.e[i] = $signed(W'($urandom_range(2 * 8 * ONE))) - 8 * ONE;
            end
            else if (shape <= 5)
            begin
                m.e[i] = W'($urandom());
            end
            else
            begin
                m.e[i] = $signed(W'($urandom_range(2 * 4 * ONE))) - 4 * ONE;
            end
        end
        case (shape)
            6:
            begin
                // Third row repeats the first, so the determinant is zero.
                for (int c = 0; c < 3; c++)
                begin
                    m.e[6+c] = m.e[c];
                end
            end
            7:
            begin
                // Third row is the sum of the first two, also singular.
                for (int c = 0; c < 3; c++)
                begin
                    m.e[6+c] = m.e[c] + m.e[3+c];
                end
            end
            8:
            begin
                // Zero leading pivot; the matrix usually stays invertible.
                m.e[0] = '0;
                if ($urandom_range(1))
                begin
                    m.e[4] = m.e[1] * 0 + m.e[3] * 0;
                end
            end
            9:
            begin
                // Scaled permutation with a few tiny or huge entries for saturation.
                p = $urandom_range(2);
                foreach (m.e[i])
                begin
                    m.e[i] = '0;
                end
                m.e[p] = W'($urandom_range(7)) + 1;
                m.e[3 + (p + 1) % 3] = W'($urandom());
                m.e[6 + (p + 2) % 3] = ONE;
            end
            default:
            begin
            end
        endcase
        return m;
    endfunction

    // Checks every result the receiver takes against the oldest expectation.
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_inverses.size() == 0)
            begin
                $display("%0t ns: result arrived with no matrix outstanding", $time);
                error_count++;
            end
            else
            begin
                want = pending_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    if (inv_e[i] !== want.e[i])
                    begin
                        report_mismatch($sformatf("inv_r%0dc%0d", i / 3, i % 3),
                                        inv_e[i], want.e[i]);
                    end
                end
                if (singular !== want.singular)
                begin
                    report_mismatch("singular", singular, want.singular);
                end
            end
        end
    end

    // The receiver stalls at random at the chosen rate.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Identity, extremes, singular cases, zero pivots, saturation and rounding.
    task automatic test_directed();
        matrix_t m;
        idle_pct  = 0;
        stall_pct = 0;
        send_matrix(diag_matrix(ONE, ONE, ONE));
        send_matrix(diag_matrix('0, '0, '0));
        send_matrix(diag_matrix(EMAX, EMAX, EMAX));
        send_matrix(diag_matrix(EMIN, EMIN, EMIN));
        send_matrix(diag_matrix(EMIN, EMAX, -ONE));
        send_matrix(diag_matrix(1, 1, 1));
        send_matrix(diag_matrix(2 * ONE, -4 * ONE, 3 * ONE));
        // Halfway quotient: 1/(2^17 raw)*2^32 is 2^15 exactly; 3*ONE gives a
        // repeating fraction that is rounded to nearest, and -3*ONE its negative.
        send_matrix(diag_matrix(ONE <<< 1, 3 * ONE, -3 * ONE));
        send_matrix(diag_matrix(W'(3) <<< 16, W'(3) <<< 14, W'(5) <<< 20));
        // Permutations: zero pivot in the leading position yet invertible.
        m = diag_matrix('0, '0, ONE);
        m.e[1] = ONE;
        m.e[3] = -ONE;
        send_matrix(m);
        m = diag_matrix('0, '0, '0);
        m.e[2] = ONE;
        m.e[4] = 2 * ONE;
        m.e[6] = EMIN;
        send_matrix(m);
        // Every element at an extreme, then every element -1 but a zero centre.
        foreach (m.e[i])
        begin
            m.e[i] = EMAX;
        end
        send_matrix(m);
        foreach (m.e[i])
        begin
            m.e[i] = (i % 2) ? EMIN : EMAX;
        end
        send_matrix(m);
        foreach (m.e[i])
        begin
            m.e[i] = (i == 0 || i == 5 || i == 7) ? EMIN : EMAX;
        end
        send_matrix(m);
        foreach (m.e[i])
        begin
            m.e[i] = -1;
        end
        m.e[4] = '0;
        send_matrix(m);
        // A general well-conditioned matrix whose inverse has negative entries.
        m.e = '{ONE, 2 * ONE, 3 * ONE, '0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, '0};
        send_matrix(m);
        go_quiet();
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            send_matrix(random_matrix());
        end
        go_quiet();
        wait_drained();
    endtask

    // The sender holds off until the pipeline is empty, then bursts again.
    task automatic test_drain_pause();
        idle_pct  = 0;
        stall_pct = 35;
        for (int n = 0; n < 40; n++)
        begin
            send_matrix(random_matrix());
        end
        go_quiet();
        wait_drained();
        repeat (LAT) @(posedge clk);
        for (int n = 0; n < 40; n++)
        begin
            send_matrix(random_matrix());
        end
        go_quiet();
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        foreach (in_e[i])
        begin
            in_e[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(260, 0, 0);
        test_random(260, 86, 0);
        test_random(260, 0, 86);
        test_random(260, 35, 35);
        test_drain_pause();

        repeat (LAT + 20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Generous bound on the whole run; a hung handshake ends here.
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- matrix_inverse_3x3.f -----
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_lane.sv
rtl/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_test.sv
